// ----- sv/sknt_pkg.sv -----
// Package for the shared-key neighbour table.
// Holds field widths, register indexes, result status codes and sequencer states.
// No dependencies.
package sknt_pkg;

   localparam int ADDR_W      = 16;
   localparam int KEY_W       = 16;
   localparam int RING_SIZE_W = 3;
   localparam int STATUS_W    = 3;
   localparam int INDEX_W     = 3;
   localparam int COUNT_W     = 4;
   localparam int KEY_POS_W   = 3;

   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_INDEX_W  = 3;
   localparam int OWN_KEY_REGS = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_RING_SIZE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_OWN_KEY_0 = 3'd1;

   localparam logic [RING_SIZE_W-1:0] RING_SIZE_RESET = 3'd4;
   localparam logic [KEY_POS_W-1:0]   KEY_POS_MAX     = 3'd7;

   typedef enum logic [STATUS_W-1:0] {
      ST_ADDED    = 3'd0,
      ST_NO_MATCH = 3'd1,
      ST_KNOWN    = 3'd2,
      ST_FULL     = 3'd3,
      ST_IGNORED  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_RING,
      S_DONE
   } seq_state_type;

endpackage

// ----- sv/sknt_req_if.sv -----
// Request channel: one advertised key with its sender and end-of-advertisement flag.
// Depends on sknt_pkg.
interface sknt_req_if;
   import sknt_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] sender_address;
   logic [KEY_W-1:0]  advertised_key;
   logic              last_key;

   modport source (output valid, output sender_address, output advertised_key,
                   output last_key, input ready);
   modport sink   (input valid, input sender_address, input advertised_key,
                   input last_key, output ready);
endinterface

// ----- sv/sknt_rsp_if.sv -----
// Response channel: status, written slot and table fill after one transaction.
// Depends on sknt_pkg.
interface sknt_rsp_if;
   import sknt_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [INDEX_W-1:0]  entry_index;
   logic [COUNT_W-1:0]  entry_count;

   modport source (output valid, output status, output entry_index,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input entry_index,
                   input entry_count, output ready);
endinterface

// ----- sv/sknt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sknt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/sknt_csr.sv -----
// Configuration registers: ring size and the own key ring, APB-style access.
// Depends on sknt_pkg.
module sknt_csr #(
   parameter int RING_KEYS = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [sknt_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [sknt_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [sknt_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output logic [sknt_pkg::RING_SIZE_W-1:0]   ring_size,
   output logic [sknt_pkg::KEY_W-1:0]         own_keys [RING_KEYS]
);
   import sknt_pkg::*;

   logic [RING_SIZE_W-1:0] ring_size_ff, ring_size_in;
   logic [KEY_W-1:0]       own_key_ff [OWN_KEY_REGS];
   logic [KEY_W-1:0]       own_key_in [OWN_KEY_REGS];
   logic [CSR_INDEX_W-1:0] reg_index;
   logic                   wr_strobe;

   assign pready    = 1'b1;
   assign reg_index = paddr[CSR_ADDR_W-1:2];
   assign wr_strobe = psel & penable & pwrite;

   always_comb begin
      ring_size_in = ring_size_ff;
      for (int k = 0; k < OWN_KEY_REGS; k++) begin
         own_key_in[k] = own_key_ff[k];
      end
      if (wr_strobe) begin
         if (reg_index == REG_RING_SIZE) begin
            ring_size_in = pwdata[RING_SIZE_W-1:0];
         end
         for (int k = 0; k < OWN_KEY_REGS; k++) begin
            if (k < RING_KEYS && reg_index == CSR_INDEX_W'(REG_OWN_KEY_0 + k)) begin
               own_key_in[k] = pwdata[KEY_W-1:0];
            end
         end
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_index == REG_RING_SIZE) begin
         prdata = CSR_DATA_W'(ring_size_ff);
      end
      for (int k = 0; k < OWN_KEY_REGS; k++) begin
         if (reg_index == CSR_INDEX_W'(REG_OWN_KEY_0 + k)) begin
            prdata = CSR_DATA_W'(own_key_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_size_ff <= RING_SIZE_RESET;
         for (int k = 0; k < OWN_KEY_REGS; k++) begin
            own_key_ff[k] <= '0;
         end
      end else begin
         ring_size_ff <= ring_size_in;
         for (int k = 0; k < OWN_KEY_REGS; k++) begin
            own_key_ff[k] <= own_key_in[k];
         end
      end
   end

   assign ring_size = ring_size_ff;

   for (genvar r = 0; r < RING_KEYS; r++) begin : g_ring
      if (r < OWN_KEY_REGS) begin : g_reg
         assign own_keys[r] = own_key_ff[r];
      end else begin : g_zero
         assign own_keys[r] = '0;
      end
   end

endmodule

// ----- sv/shared_key_neighbour_table.sv -----
// Shared-key neighbour table: one sequencer and one shared 16-bit equality comparator.
// Depends on sknt_pkg, sknt_req_if, sknt_rsp_if, sknt_ram and sknt_csr.
//
// Each request transaction carries one key of a neighbour's key advertisement,
// the sender's short address and a flag on the advertisement's last key. Each
// request yields exactly one response transaction: status, the slot written
// (when added) and the table fill after the request.
// Registers ring_size and own_key_0..3 sit on the APB-style port at 4*index;
// write them only while the block is idle.
// A key that is not examined (status ignored) goes from acceptance straight to
// S_DONE, which loads the response register. An examined key walks the stored
// sender addresses one per cycle through the table RAM's registered read port and
// stops at a match; if none matches and the table is not full, it walks the own
// ring keys one per cycle (up to the smaller of ring_size and RING_KEYS), then
// S_DONE loads the response. One request is in work at a time; req ready is high
// only while the sequencer is idle, so the next request waits for S_IDLE.
// A finished response waits in the output register; when the receiver stalls,
// the next request is still accepted and worked, and holds in its last step
// until the output register frees.
// Reset empties the table, clears the advertisement position and sets
// ring_size to 4 and the own keys to zero. No clearing pass is needed.
module shared_key_neighbour_table #(
   parameter int TABLE_DEPTH = 8,
   parameter int RING_KEYS   = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   sknt_req_if.sink                        req_chan,
   sknt_rsp_if.source                      rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [sknt_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [sknt_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [sknt_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import sknt_pkg::*;

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int RW = (RING_KEYS > 1) ? $clog2(RING_KEYS) : 1;

   logic [RING_SIZE_W-1:0] ring_size;
   logic [KEY_W-1:0]       own_keys [RING_KEYS];
   logic [RING_SIZE_W-1:0] limit;

   seq_state_type          state_ff, state_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic                   last_ff, last_in;
   logic [CW-1:0]          scan_ff, scan_in;
   logic                   pend_ff, pend_in;
   logic [RING_SIZE_W-1:0] ring_ff, ring_in;
   status_type             status_ff, status_in;
   logic [CW-1:0]          slot_ff, slot_in;
   logic [CW-1:0]          fill_ff, fill_in;
   logic [KEY_POS_W-1:0]   key_pos_ff, key_pos_in;
   logic                   resolved_ff, resolved_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]     rsp_index_ff, rsp_index_in;
   logic [COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   logic [ADDR_W-1:0]      table_rd_data;
   logic                   table_we;
   logic [KEY_W-1:0]       cmp_a, cmp_b;
   logic                   match;
   logic                   out_free;

   sknt_csr #(
      .RING_KEYS (RING_KEYS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .ring_size (ring_size),
      .own_keys  (own_keys)
   );

   sknt_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (TABLE_DEPTH)
   ) u_addr_ram (
      .clock   (clock),
      .wr_en   (table_we),
      .wr_addr (fill_ff[IW-1:0]),
      .wr_data (addr_ff),
      .rd_addr (scan_ff[IW-1:0]),
      .rd_data (table_rd_data)
   );

   assign limit = (ring_size > RING_SIZE_W'(RING_KEYS)) ? RING_SIZE_W'(RING_KEYS) : ring_size;

   assign cmp_a = (state_ff == S_SCAN) ? table_rd_data : own_keys[ring_ff[RW-1:0]];
   assign cmp_b = (state_ff == S_SCAN) ? addr_ff : key_ff;
   assign match = (cmp_a == cmp_b);

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      key_in        = key_ff;
      last_in       = last_ff;
      scan_in       = scan_ff;
      pend_in       = pend_ff;
      ring_in       = ring_ff;
      status_in     = status_ff;
      slot_in       = slot_ff;
      fill_in       = fill_ff;
      key_pos_in    = key_pos_ff;
      resolved_in   = resolved_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;
      table_we      = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               addr_in = req_chan.sender_address;
               key_in  = req_chan.advertised_key;
               last_in = req_chan.last_key;
               scan_in = '0;
               pend_in = 1'b0;
               ring_in = '0;
               slot_in = '0;
               if (!resolved_ff && key_pos_ff < KEY_POS_W'(limit)) begin
                  state_in = S_SCAN;
               end else begin
                  status_in = ST_IGNORED;
                  state_in  = S_DONE;
               end
            end
         end
         S_SCAN: begin
            if (pend_ff && match) begin
               status_in = ST_KNOWN;
               state_in  = S_DONE;
            end else if (scan_ff < fill_ff) begin
               scan_in = scan_ff + CW'(1);
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  if (fill_ff >= CW'(TABLE_DEPTH)) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_RING;
                  end
               end
            end
         end
         S_RING: begin
            if (match) begin
               table_we  = 1'b1;
               slot_in   = fill_ff;
               fill_in   = fill_ff + CW'(1);
               status_in = ST_ADDED;
               state_in  = S_DONE;
            end else if (ring_ff + RING_SIZE_W'(1) >= limit) begin
               status_in = ST_NO_MATCH;
               state_in  = S_DONE;
            end else begin
               ring_in = ring_ff + RING_SIZE_W'(1);
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_index_in  = INDEX_W'(slot_ff);
               rsp_count_in  = COUNT_W'(fill_ff);
               if (last_ff) begin
                  key_pos_in  = '0;
                  resolved_in = 1'b0;
               end else begin
                  if (key_pos_ff != KEY_POS_MAX) begin
                     key_pos_in = key_pos_ff + KEY_POS_W'(1);
                  end
                  resolved_in = resolved_ff || status_ff == ST_ADDED ||
                                status_ff == ST_KNOWN || status_ff == ST_FULL;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         fill_ff      <= '0;
         key_pos_ff   <= '0;
         resolved_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         fill_ff      <= fill_in;
         key_pos_ff   <= key_pos_in;
         resolved_ff  <= resolved_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      key_ff        <= key_in;
      last_ff       <= last_in;
      scan_ff       <= scan_in;
      ring_ff       <= ring_in;
      status_ff     <= status_in;
      slot_ff       <= slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.entry_index = rsp_index_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

endmodule
